// ----- rtl/four_channel_down_timer_core_defines.svh -----
// ----------------------------------------------------------------------------
// four_channel_down_timer_core_defines
// assertion macros shared by the timer core
// ----------------------------------------------------------------------------
`ifndef FOUR_CHANNEL_DOWN_TIMER_CORE_DEFINES_SVH
`define FOUR_CHANNEL_DOWN_TIMER_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define FCDT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle timer check failed");

// next-cycle implication, disabled while in reset
`define FCDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle timer check failed");

`endif

// ----- rtl/fcdt_pkg.sv -----
// ----------------------------------------------------------------------------
// fcdt_pkg
// types and constants of the four-channel down timer
// ----------------------------------------------------------------------------
`default_nettype none

package fcdt_pkg;

	localparam int unsigned CHANNELS_DEF = 4;
	localparam int unsigned IVAL_W       = 31;
	localparam int unsigned CTRL_W       = 3;
	localparam int unsigned CHAN_W       = 4;
	localparam int unsigned TIMER_BITS   = 31;

	localparam logic [7:0] OFF_MODCFG = 8'hF0;
	localparam logic [7:0] OFF_IDLE   = 8'hF4;
	localparam logic [7:0] OFF_FLAGS  = 8'hF8;
	localparam logic [8:0] WINDOW     = 9'h100;

	localparam logic [1:0] MODE_PERIODIC = 2'd0;

	// configuration register indexes
	localparam logic [1:0] CFG_PERIPH_EN = 2'd0;
	localparam logic [1:0] CFG_IRQ_CONN  = 2'd1;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		SUB_INTVAL,
		SUB_TIMER,
		SUB_CTRL,
		SUB_STAT,
		SUB_NONE
	} sub_t;

	// decoded item, write and tick actions already qualified by the stage advancing
	typedef struct packed {
		logic              ok;
		logic              chan_rd;
		logic              chan_wr;
		logic              flags_wr;
		logic              rd_modcfg;
		logic              rd_idle;
		logic              rd_flags;
		logic              tick;
		logic [CHAN_W-1:0] chan;
		sub_t              sub;
	} acc_t;

	// per-channel status towards the global logic
	typedef struct packed {
		logic running;
		logic fired;
		logic stat_clr;
	} chan_stat_t;

endpackage

`default_nettype wire

// ----- rtl/fcdt_decode.sv -----
// ----------------------------------------------------------------------------
// fcdt_decode
// access checks and register decode of the held item
// ----------------------------------------------------------------------------
`default_nettype none

module fcdt_decode #(
	parameter int unsigned CHANNELS = fcdt_pkg::CHANNELS_DEF
) (
	input  wire logic        go,
	input  wire logic        enabled,
	input  wire logic [1:0]  cmd,
	input  wire logic [7:0]  offset,
	input  wire logic [2:0]  xfer_size,
	input  wire logic [31:0] tick_cycles,
	output fcdt_pkg::acc_t   acc
);
	import fcdt_pkg::*;

	localparam logic [8:0] CHAN_AREA = 9'(CHANNELS * 16);

	logic [8:0] end_off;
	logic       acc_ok;
	logic       is_rd;
	logic       is_wr;
	logic       is_tick;
	logic       in_area;
	logic       hit_modcfg;
	logic       hit_idle;
	logic       hit_flags;
	sub_t       sub_d;

	// size, window and peripheral enable checks
	assign end_off = {1'b0, offset} + {6'd0, xfer_size};
	assign acc_ok  = (xfer_size != 3'd0) && (xfer_size <= 3'd4) &&
		(end_off <= WINDOW) && enabled;

	// command decode
	always_comb begin
		is_rd   = 1'b0;
		is_wr   = 1'b0;
		is_tick = 1'b0;
		unique case (cmd)
			CMD_READ:  is_rd   = 1'b1;
			CMD_WRITE: is_wr   = 1'b1;
			CMD_TICK:  is_tick = 1'b1;
			default:   ;
		endcase
	end

	assign in_area    = {1'b0, offset} < CHAN_AREA;
	assign hit_modcfg = offset == OFF_MODCFG;
	assign hit_idle   = offset == OFF_IDLE;
	assign hit_flags  = offset == OFF_FLAGS;

	// sub-register within a channel, unaligned offsets map to nothing
	always_comb begin
		sub_d = SUB_NONE;
		if (offset[1:0] == 2'd0) begin
			unique case (offset[3:2])
				2'd0: sub_d = SUB_INTVAL;
				2'd1: sub_d = SUB_TIMER;
				2'd2: sub_d = SUB_CTRL;
				2'd3: sub_d = SUB_STAT;
			endcase
		end
	end

	// globals win over channel registers on reads, only the flag word on writes
	assign acc.sub       = sub_d;
	assign acc.ok        = ((is_rd || is_wr) && acc_ok) || is_tick;
	assign acc.chan_rd   = is_rd && acc_ok && in_area && !hit_modcfg && !hit_idle &&
		!hit_flags;
	assign acc.chan_wr   = go && is_wr && acc_ok && in_area && !hit_flags;
	assign acc.flags_wr  = go && is_wr && acc_ok && hit_flags;
	assign acc.rd_modcfg = is_rd && acc_ok && hit_modcfg;
	assign acc.rd_idle   = is_rd && acc_ok && hit_idle;
	assign acc.rd_flags  = is_rd && acc_ok && hit_flags;
	assign acc.tick      = go && is_tick && enabled && (tick_cycles != 32'd0);
	assign acc.chan      = offset[7:4];

endmodule

`default_nettype wire

// ----- rtl/fcdt_chan.sv -----
// ----------------------------------------------------------------------------
// fcdt_chan
// one timer channel: interval, counter, control and status
// ----------------------------------------------------------------------------
`default_nettype none

module fcdt_chan #(
	parameter int unsigned CH_IDX = 0
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  fcdt_pkg::acc_t           acc,
	input  wire logic [31:0]         write_data,
	input  wire logic [31:0]         step,
	output logic [31:0]              rdata,
	output fcdt_pkg::chan_stat_t     stat
);
	import fcdt_pkg::*;

	logic [IVAL_W-1:0] ival_q, ival_nx;
	logic [IVAL_W-1:0] cnt_q, cnt_nx;
	logic [CTRL_W-1:0] ctrl_q, ctrl_nx;
	logic              flag_q, flag_nx;
	logic              run_q, run_nx;
	logic              sel;
	logic              fired;
	logic              stat_clr;
	logic [IVAL_W-1:0] new_ival;

	assign sel      = acc.chan == CHAN_W'(CH_IDX);
	assign new_ival = write_data[IVAL_W-1:0];

	// register reads of this channel
	always_comb begin
		rdata = 32'd0;
		if (acc.chan_rd && sel) begin
			unique case (acc.sub)
				SUB_INTVAL: rdata = {1'b0, ival_q};
				SUB_TIMER:  rdata = {1'b0, cnt_q};
				SUB_CTRL:   rdata = {29'd0, ctrl_q};
				SUB_STAT:   rdata = {30'd0, run_q, flag_q};
				SUB_NONE:   rdata = 32'd0;
			endcase
		end
	end

	// bus writes and tick countdown
	always_comb begin
		ival_nx  = ival_q;
		cnt_nx   = cnt_q;
		ctrl_nx  = ctrl_q;
		flag_nx  = flag_q;
		run_nx   = run_q;
		fired    = 1'b0;
		stat_clr = 1'b0;
		if (acc.chan_wr && sel) begin
			unique case (acc.sub)
				SUB_INTVAL: begin
					ival_nx = new_ival;
					if (write_data[31] || (new_ival == '0) || (cnt_q == '0)) begin
						cnt_nx = new_ival;
					end
					run_nx = new_ival != '0;
				end
				SUB_CTRL: ctrl_nx = write_data[CTRL_W-1:0];
				SUB_STAT: begin
					if (write_data[0]) begin
						flag_nx  = 1'b0;
						stat_clr = 1'b1;
					end
				end
				SUB_TIMER, SUB_NONE: ;
			endcase
		end else if (acc.tick && run_q && (cnt_q != '0)) begin
			if ({1'b0, cnt_q} <= step) begin
				fired   = 1'b1;
				flag_nx = 1'b1;
				if ((ctrl_q[2:1] == MODE_PERIODIC) && (ival_q != '0)) begin
					cnt_nx = ival_q;
				end else begin
					cnt_nx = '0;
					run_nx = 1'b0;
				end
			end else begin
				cnt_nx = cnt_q - step[IVAL_W-1:0];
			end
		end
	end

	// channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ival_q <= '0;
			cnt_q  <= '0;
			ctrl_q <= '0;
			flag_q <= 1'b0;
			run_q  <= 1'b0;
		end else begin
			ival_q <= ival_nx;
			cnt_q  <= cnt_nx;
			ctrl_q <= ctrl_nx;
			flag_q <= flag_nx;
			run_q  <= run_nx;
		end
	end

	assign stat.running  = run_q;
	assign stat.fired    = fired;
	assign stat.stat_clr = stat_clr;

endmodule

`default_nettype wire

// ----- rtl/four_channel_down_timer_core.sv -----
// ----------------------------------------------------------------------------
// four_channel_down_timer_core: a beat passes the input stage, then the result register
// throughput one beat per cycle if results drain; all channels update as a beat advances
// a waiting result stalls the input only once the input stage also holds a beat
// reset clears all channel state, flags and pending level; both config bits reset to 1
// ----------------------------------------------------------------------------
`default_nettype none

module four_channel_down_timer_core #(
	parameter int unsigned CHANNELS = fcdt_pkg::CHANNELS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic [7:0]  offset,
	input  wire logic [2:0]  xfer_size,
	input  wire logic [31:0] write_data,
	input  wire logic [31:0] tick_cycles,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             ok,
	output logic [31:0]      read_data,
	output logic             irq_pending,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic        cfg_data
);
	import fcdt_pkg::*;

	`include "four_channel_down_timer_core_defines.svh"

	localparam int unsigned IDLE_W = $clog2(CHANNELS + 1);
	localparam logic [31:0] MODCFG_VAL = {23'd0, 5'(TIMER_BITS), 4'(CHANNELS - 1)};

	// input stage
	logic        valid_s1;
	logic [1:0]  cmd_s1;
	logic [7:0]  offset_s1;
	logic [2:0]  size_s1;
	logic [31:0] wdata_s1;
	logic [31:0] tick_s1;

	// configuration
	logic periph_en_q;
	logic irq_conn_q;

	// result register
	logic        out_valid_q;
	logic        ok_q;
	logic [31:0] rdata_q;
	logic        irq_q;

	// global state
	logic [CHANNELS-1:0] flags_q;
	logic                pending_q;

	logic                advance;
	acc_t                acc;
	chan_stat_t          stat [CHANNELS];
	logic [31:0]         ch_rdata [CHANNELS];
	logic [31:0]         ch_rdata_or;
	logic [CHANNELS-1:0] fire_mask;
	logic [CHANNELS-1:0] clr_mask;
	logic [CHANNELS-1:0] flags_nx;
	logic                pending_nx;
	logic [IDLE_W-1:0]   idle_idx;
	logic [31:0]         rdata_nx;

	// handshake: the held beat moves on whenever the result register is free or being read
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1    <= cmd;
			offset_s1 <= offset;
			size_s1   <= xfer_size;
			wdata_s1  <= write_data;
			tick_s1   <= tick_cycles;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			periph_en_q <= 1'b1;
			irq_conn_q  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PERIPH_EN: periph_en_q <= cfg_data;
				CFG_IRQ_CONN:  irq_conn_q  <= cfg_data;
				default:       ;
			endcase
		end
	end

	fcdt_decode #(
		.CHANNELS(CHANNELS)
	) u_decode (
		.go         (advance),
		.enabled    (periph_en_q),
		.cmd        (cmd_s1),
		.offset     (offset_s1),
		.xfer_size  (size_s1),
		.tick_cycles(tick_s1),
		.acc        (acc)
	);

	// channels
	for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
		fcdt_chan #(
			.CH_IDX(g)
		) u_chan (
			.clk       (clk),
			.arst_n    (arst_n),
			.acc       (acc),
			.write_data(wdata_s1),
			.step      (tick_s1),
			.rdata     (ch_rdata[g]),
			.stat      (stat[g])
		);
		assign fire_mask[g] = stat[g].fired;
	end

	// channel read data and first idle channel
	always_comb begin
		ch_rdata_or = 32'd0;
		idle_idx    = IDLE_W'(CHANNELS);
		clr_mask    = '0;
		for (int i = CHANNELS - 1; i >= 0; i--) begin
			ch_rdata_or = ch_rdata_or | ch_rdata[i];
			clr_mask[i] = stat[i].stat_clr;
			if (!stat[i].running) begin
				idle_idx = IDLE_W'(i);
			end
		end
		if (acc.flags_wr) begin
			clr_mask = clr_mask | wdata_s1[CHANNELS-1:0];
		end
	end

	// global flags and interrupt level
	always_comb begin
		flags_nx   = (flags_q & ~clr_mask) | fire_mask;
		pending_nx = pending_q;
		if ((|fire_mask) && irq_conn_q) begin
			pending_nx = 1'b1;
		end else if ((acc.flags_wr || (|clr_mask)) && (flags_nx == '0) && irq_conn_q) begin
			pending_nx = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q   <= '0;
			pending_q <= 1'b0;
		end else begin
			flags_q   <= flags_nx;
			pending_q <= pending_nx;
		end
	end

	// read mux, global registers first
	always_comb begin
		priority if (acc.rd_modcfg) begin
			rdata_nx = MODCFG_VAL;
		end else if (acc.rd_idle) begin
			rdata_nx = 32'(idle_idx) << 4;
		end else if (acc.rd_flags) begin
			rdata_nx = 32'(flags_q);
		end else begin
			rdata_nx = ch_rdata_or;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ok_q    <= acc.ok;
			rdata_q <= rdata_nx;
			irq_q   <= pending_nx;
		end
	end

	assign out_valid   = out_valid_q;
	assign ok          = ok_q;
	assign read_data   = rdata_q;
	assign irq_pending = irq_q;

	// checks
	`FCDT_ASSERT_IMPL(a_accept_when_free, clk, arst_n, !out_valid_q || out_ready, in_ready)
	`FCDT_ASSERT_NEXT(a_level_held_detached, clk, arst_n, !irq_conn_q, $stable(pending_q))
	`FCDT_ASSERT_NEXT(a_fire_raises_level, clk, arst_n, (|fire_mask) && irq_conn_q, pending_q && irq_pending)
	`FCDT_ASSERT_NEXT(a_no_result_without_beat, clk, arst_n, !out_valid_q && !advance, !out_valid_q)

endmodule

`default_nettype wire
